// ----- sv/failure_burst_window_detector_unit_defines.svh -----
// Assertion macros shared by the failure burst window detector RTL.
`ifndef FAILURE_BURST_WINDOW_DETECTOR_UNIT_DEFINES_SVH
`define FAILURE_BURST_WINDOW_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fbwd_pkg.sv -----
// Package: codes, reset values and shared types of the failure burst window detector.
package fbwd_pkg;

    localparam int LIMIT_W    = 16;
    localparam int RATE_W     = 12;
    localparam int WLEN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MEAN_FLOOR = 10;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_RESET  = 2'd3;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_BELOW = 2'd1;
    localparam logic [1:0] CAUSE_ABS   = 2'd2;
    localparam logic [1:0] CAUSE_REL   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ABS_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 2'd2;

    localparam logic [LIMIT_W-1:0] ABS_LIMIT_RST = 16'd100;
    localparam logic [RATE_W-1:0]  REL_RATE_RST  = 12'd256;
    localparam logic [WLEN_W-1:0]  WIN_LEN_RST   = 5'd10;

    // Check flags handed from the window stage to the decision stage.
    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       abs_hit;
        logic       floor_ok;
    } t_chk_flags;

endpackage

// ----- sv/fbwd_cell.sv -----
// One cell of the count chain: holds one count and shifts toward the oldest end.
module fbwd_cell #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic                  i_entry,
    input  logic [COUNT_BITS-1:0] i_new,
    input  logic [COUNT_BITS-1:0] i_prev,
    output logic [COUNT_BITS-1:0] o_q
);

    logic [COUNT_BITS-1:0] r_q;

    // The entry cell takes the new count, all others take their neighbor.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_entry ? i_new : i_prev;
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/fbwd_window.sv -----
// Window stage: cell chain, running sum, fill level and the check operand registers.
module fbwd_window #(
    parameter int WINDOW_MAX = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  logic                                   i_clear,
    input  logic [1:0]                             i_mode,
    input  logic [COUNT_BITS-1:0]                  i_count,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]        i_len,
    input  logic [fbwd_pkg::LIMIT_W-1:0]           i_limit,
    input  logic [fbwd_pkg::RATE_W-1:0]            i_rate,
    output fbwd_pkg::t_chk_flags                   o_flags,
    output logic [COUNT_BITS+$clog2(WINDOW_MAX+1)-1:0] o_cl,
    output logic [COUNT_BITS+$clog2(WINDOW_MAX)-1:0]   o_sum,
    output logic [fbwd_pkg::RATE_W+COUNT_BITS+$clog2(WINDOW_MAX)-1:0] o_allowed,
    output logic [$clog2(WINDOW_MAX+1)-1:0]        o_fill
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int SUM_W = COUNT_BITS + $clog2(WINDOW_MAX);
    localparam int CL_W  = COUNT_BITS + LEN_W;
    localparam int AL_W  = fbwd_pkg::RATE_W + SUM_W;

    logic [COUNT_BITS-1:0] w_q [WINDOW_MAX];
    logic [LEN_W-1:0]      w_start_full;
    logic [IDX_W-1:0]      w_start;
    logic                  w_shift;
    logic [COUNT_BITS-1:0] w_oldest;

    logic [LEN_W-1:0]      r_fill, n_fill;
    logic [SUM_W-1:0]      r_sum, n_sum;

    fbwd_pkg::t_chk_flags  r_p_flags;
    logic [CL_W-1:0]       r_p_cl;
    logic [SUM_W-1:0]      r_p_sum;
    logic [AL_W-1:0]       r_p_allowed;
    logic [LEN_W-1:0]      r_p_fill;

    // New counts enter at cell WINDOW_MAX-len, so the oldest of a full window
    // always sits in the last cell.
    assign w_start_full = LEN_W'(WINDOW_MAX) - i_len;
    assign w_start      = w_start_full[IDX_W-1:0];
    assign w_shift      = i_push && (i_mode == fbwd_pkg::MODE_STEP);
    assign w_oldest     = w_q[WINDOW_MAX-1];

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        if (k == 0) begin : g_head
            fbwd_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_start == IDX_W'(k)),
                .i_new   (i_count),
                .i_prev  (i_count),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            fbwd_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_start == IDX_W'(k)),
                .i_new   (i_count),
                .i_prev  (w_q[k-1]),
                .o_q     (w_q[k])
            );
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_sum  = r_sum;
        if (i_clear) begin
            n_fill = '0;
            n_sum  = '0;
        end else if (i_push) begin
            case (i_mode)
                fbwd_pkg::MODE_STEP: begin
                    if (r_fill == i_len) begin
                        n_sum = r_sum - SUM_W'(w_oldest) + SUM_W'(i_count);
                    end else begin
                        n_fill = r_fill + LEN_W'(1);
                        n_sum  = r_sum + SUM_W'(i_count);
                    end
                end
                fbwd_pkg::MODE_UPDATE, fbwd_pkg::MODE_RESET: begin
                    n_fill = '0;
                    n_sum  = '0;
                end
                default: begin
                    n_fill = r_fill;
                    n_sum  = r_sum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    // Check operands come from the window as it stood before this word.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_p_flags.mode     <= i_mode;
            r_p_flags.full     <= (r_fill == i_len);
            r_p_flags.abs_hit  <= (32'(i_count) > 32'(i_limit));
            r_p_flags.floor_ok <= (r_sum >= SUM_W'(i_len) * SUM_W'(fbwd_pkg::MEAN_FLOOR));
            r_p_cl             <= CL_W'(i_count) * CL_W'(i_len);
            r_p_sum            <= r_sum;
            r_p_allowed        <= AL_W'(i_rate) * AL_W'(r_sum);
            r_p_fill           <= n_fill;
        end
    end

    assign o_flags   = r_p_flags;
    assign o_cl      = r_p_cl;
    assign o_sum     = r_p_sum;
    assign o_allowed = r_p_allowed;
    assign o_fill    = r_p_fill;

endmodule

// ----- sv/failure_burst_window_detector_unit.sv -----
// Each input word's operands are registered in the window stage, its result in the output register.
// Throughput: one word per cycle unless the output stalls, set by the running-sum and cell chain update.
// A stalled output register holds the decision stage; the input side stalls only when both are full.
// Reset (synchronous, active low) empties the window, clears both counters and the pipeline,
// and loads the registers with limit 100, rate 256 (1.0) and window length 10.
`include "failure_burst_window_detector_unit_defines.svh"

module failure_burst_window_detector_unit #(
    parameter int WINDOW_MAX = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] failure_count
    input  logic [1:0]                          s_axis_tuser,  // [1:0] mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [71:0]                         m_axis_tdata,  // [31:0] hit_total,
                                                               // [63:32] miss_total,
                                                               // [68:64] window_fill
    output logic [2:0]                          m_axis_tuser,  // [0] triggered, [2:1] cause
    input  logic                                i_cfg_we,
    input  logic [fbwd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbwd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = COUNT_BITS + $clog2(WINDOW_MAX);
    localparam int CL_W  = COUNT_BITS + LEN_W;
    localparam int AL_W  = fbwd_pkg::RATE_W + SUM_W;
    localparam int SH_W  = CL_W + 8;
    localparam int CMP_W = ((SH_W > AL_W) ? SH_W : AL_W) + 1;

    logic [fbwd_pkg::LIMIT_W-1:0] r_abs_limit;
    logic [fbwd_pkg::RATE_W-1:0]  r_rate;
    logic [fbwd_pkg::WLEN_W-1:0]  r_wlen;
    logic [LEN_W-1:0]             w_len;
    logic                         w_len_clear;

    logic                         w_in_acc;
    logic                         w_out_adv;
    logic [COUNT_BITS-1:0]        w_count;

    fbwd_pkg::t_chk_flags         w_p_flags;
    logic [CL_W-1:0]              w_p_cl;
    logic [SUM_W-1:0]             w_p_sum;
    logic [AL_W-1:0]              w_p_allowed;
    logic [LEN_W-1:0]             w_p_fill;

    logic [CL_W-1:0]              w_diff;
    logic                         w_rel_hit;
    logic [1:0]                   w_cause;
    logic [31:0]                  n_hit, n_miss;

    logic                         r_p_v;
    logic                         r_o_v;
    logic                         r_o_trig;
    logic [1:0]                   r_o_cause;
    logic [fbwd_pkg::WLEN_W-1:0]  r_o_fill;
    logic [31:0]                  r_hit, r_miss;

    logic                         w_o_fired;
    logic                         w_o_held;
    logic                         w_step_adv;

    // Register writes; a window length write also empties the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_limit <= fbwd_pkg::ABS_LIMIT_RST;
            r_rate      <= fbwd_pkg::REL_RATE_RST;
            r_wlen      <= fbwd_pkg::WIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fbwd_pkg::CFG_ABS_LIMIT: r_abs_limit <= i_cfg_wdata[fbwd_pkg::LIMIT_W-1:0];
                fbwd_pkg::CFG_REL_RATE:  r_rate      <= i_cfg_wdata[fbwd_pkg::RATE_W-1:0];
                fbwd_pkg::CFG_WIN_LEN:   r_wlen      <= i_cfg_wdata[fbwd_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_len_clear = i_cfg_we && (i_cfg_idx == fbwd_pkg::CFG_WIN_LEN);

    // Length in force: zero acts as one, anything past the chain acts as the chain.
    always_comb begin
        if (r_wlen == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_wlen) > 32'(WINDOW_MAX)) begin
            w_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_len = LEN_W'(r_wlen);
        end
    end

    assign w_out_adv     = !r_o_v || m_axis_tready;
    assign s_axis_tready = !r_p_v || w_out_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_count       = COUNT_BITS'(s_axis_tdata);

    fbwd_window #(
        .WINDOW_MAX (WINDOW_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_in_acc),
        .i_clear   (w_len_clear),
        .i_mode    (s_axis_tuser),
        .i_count   (w_count),
        .i_len     (w_len),
        .i_limit   (r_abs_limit),
        .i_rate    (r_rate),
        .o_flags   (w_p_flags),
        .o_cl      (w_p_cl),
        .o_sum     (w_p_sum),
        .o_allowed (w_p_allowed),
        .o_fill    (w_p_fill)
    );

    // Relative test: (count*len - sum)*256 > rate*sum, only if count*len > sum and sum >= 10*len.
    assign w_diff    = w_p_cl - CL_W'(w_p_sum);
    assign w_rel_hit = w_p_flags.floor_ok && (w_p_cl > CL_W'(w_p_sum))
                       && (CMP_W'({w_diff, 8'h00}) > CMP_W'(w_p_allowed));

    always_comb begin
        case (w_p_flags.mode)
            fbwd_pkg::MODE_CHECK: begin
                if (!w_p_flags.full) begin
                    w_cause = fbwd_pkg::CAUSE_NONE;
                end else if (w_p_flags.abs_hit) begin
                    w_cause = fbwd_pkg::CAUSE_ABS;
                end else if (w_rel_hit) begin
                    w_cause = fbwd_pkg::CAUSE_REL;
                end else begin
                    w_cause = fbwd_pkg::CAUSE_BELOW;
                end
            end
            default: w_cause = fbwd_pkg::CAUSE_NONE;
        endcase
    end

    always_comb begin
        n_hit  = r_hit;
        n_miss = r_miss;
        case (w_p_flags.mode)
            fbwd_pkg::MODE_CHECK: begin
                if (w_cause == fbwd_pkg::CAUSE_ABS || w_cause == fbwd_pkg::CAUSE_REL) begin
                    n_hit = (r_hit == '1) ? r_hit : r_hit + 32'd1;
                end else begin
                    n_miss = (r_miss == '1) ? r_miss : r_miss + 32'd1;
                end
            end
            fbwd_pkg::MODE_RESET: begin
                n_hit  = '0;
                n_miss = '0;
            end
            default: begin
                n_hit  = r_hit;
                n_miss = r_miss;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v  <= 1'b0;
            r_o_v  <= 1'b0;
            r_hit  <= '0;
            r_miss <= '0;
        end else begin
            if (s_axis_tready) begin
                r_p_v <= s_axis_tvalid;
            end
            if (w_out_adv) begin
                r_o_v <= r_p_v;
                if (r_p_v) begin
                    r_hit  <= n_hit;
                    r_miss <= n_miss;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_p_v) begin
            r_o_trig  <= (w_cause == fbwd_pkg::CAUSE_ABS) || (w_cause == fbwd_pkg::CAUSE_REL);
            r_o_cause <= w_cause;
            r_o_fill  <= fbwd_pkg::WLEN_W'(w_p_fill);
        end
    end

    // Counters only move when a word enters the output register, so they match the held word.
    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {3'b000, r_o_fill, r_miss, r_hit};
    assign m_axis_tuser  = {r_o_cause, r_o_trig};

    assign w_o_fired  = (r_o_cause == fbwd_pkg::CAUSE_ABS) || (r_o_cause == fbwd_pkg::CAUSE_REL);
    assign w_o_held   = r_o_v && !m_axis_tready;
    assign w_step_adv = w_out_adv && r_p_v && (w_p_flags.mode == fbwd_pkg::MODE_STEP);

    `FBWD_ASSERT_NOW(a_trig_cause, i_clk, i_rst_n, r_o_v, r_o_trig == w_o_fired, "trig vs cause")
    `FBWD_ASSERT_NOW(a_stall, i_clk, i_rst_n, !s_axis_tready, r_p_v && w_o_held, "early stall")
    `FBWD_ASSERT_NEXT(a_hold_ctr, i_clk, i_rst_n, w_o_held, $stable({r_hit, r_miss}), "ctr moved")
    `FBWD_ASSERT_NEXT(a_step, i_clk, i_rst_n, w_step_adv, $stable({r_hit, r_miss}), "step ctr")

endmodule

// ----- sim/failure_burst_window_detector_unit_checker.sv -----
// Checker for the failure burst window detector: follows register writes, predicts and compares.
`timescale 1ns / 100ps

module failure_burst_window_detector_unit_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] failure_count
    input  logic [1:0]                          s_axis_tuser,  // [1:0] mode
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [71:0]                         m_axis_tdata,  // [31:0] hit_total,
                                                               // [63:32] miss_total,
                                                               // [68:64] window_fill
    input  logic [2:0]                          m_axis_tuser,  // [0] triggered, [2:1] cause
    input  logic                                i_cfg_we,
    input  logic [fbwd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbwd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output int                                  o_mismatches,
    output int                                  o_pending
);

    typedef struct packed {
        logic        triggered;
        logic [1:0]  cause;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [4:0]  fill;
    } t_window_result;

    localparam int DUE_DEPTH = 16;

    // Registers as the block should hold them
    logic [fbwd_pkg::LIMIT_W-1:0] abs_limit;
    logic [fbwd_pkg::RATE_W-1:0]  rate_q8;
    logic [fbwd_pkg::WLEN_W-1:0]  win_len_reg;

    // Window and counters
    logic [15:0] ring [16];
    logic [3:0]  wr_slot;
    logic [4:0]  fill;
    logic [19:0] sum;
    logic [31:0] hits;
    logic [31:0] misses;

    // Expected words in order, oldest at due_head
    t_window_result due_words [DUE_DEPTH];
    int due_head = 0;
    int due_tail = 0;
    int mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [4:0] active_length();
        if (win_len_reg == 5'd0) return 5'd1;
        if (win_len_reg > 5'd16) return 5'd16;
        return win_len_reg;
    endfunction

    function automatic void clear_window();
        wr_slot = '0;
        fill = '0;
        sum = '0;
    endfunction

    function automatic t_window_result advance_window(logic [1:0] mode, logic [15:0] cnt);
        t_window_result r;
        logic [4:0] len;
        logic [3:0] oldest;
        longint c_l, len_l, sum_l, excess, allowed;
        r = '0;
        len = active_length();
        case (mode)
            fbwd_pkg::MODE_STEP: begin
                if (fill >= len) begin
                    // len of 16 wraps to the write slot itself
                    oldest = wr_slot - len[3:0];
                    sum = sum - ring[oldest];
                end else begin
                    fill = fill + 5'd1;
                end
                ring[wr_slot] = cnt;
                sum = sum + cnt;
                wr_slot = wr_slot + 4'd1;
            end
            fbwd_pkg::MODE_CHECK: begin
                if (fill != len) begin
                    r.cause = fbwd_pkg::CAUSE_NONE;
                end else if (cnt > abs_limit) begin
                    r.cause = fbwd_pkg::CAUSE_ABS;
                end else begin
                    r.cause = fbwd_pkg::CAUSE_BELOW;
                    if (sum >= fbwd_pkg::MEAN_FLOOR * len) begin
                        c_l = cnt;
                        len_l = len;
                        sum_l = sum;
                        excess = (c_l * len_l - sum_l) * 256;
                        allowed = longint'(rate_q8) * sum_l;
                        if (excess > allowed) r.cause = fbwd_pkg::CAUSE_REL;
                    end
                end
                if (r.cause == fbwd_pkg::CAUSE_ABS || r.cause == fbwd_pkg::CAUSE_REL) begin
                    r.triggered = 1'b1;
                    if (hits != '1) hits = hits + 32'd1;
                end else begin
                    if (misses != '1) misses = misses + 32'd1;
                end
            end
            fbwd_pkg::MODE_UPDATE: clear_window();
            default: begin
                clear_window();
                hits = '0;
                misses = '0;
            end
        endcase
        r.hits = hits;
        r.misses = misses;
        r.fill = fill;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_window_result got;
        t_window_result want;
        if (!i_rst_n) begin
            abs_limit = fbwd_pkg::ABS_LIMIT_RST;
            rate_q8 = fbwd_pkg::REL_RATE_RST;
            win_len_reg = fbwd_pkg::WIN_LEN_RST;
            clear_window();
            hits = '0;
            misses = '0;
            due_head = 0;
            due_tail = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.triggered = m_axis_tuser[0];
                got.cause = m_axis_tuser[2:1];
                got.hits = m_axis_tdata[31:0];
                got.misses = m_axis_tdata[63:32];
                got.fill = m_axis_tdata[68:64];
                if (due_tail == due_head) begin
                    $error("result word with nothing outstanding");
                    mismatch_count++;
                end else begin
                    want = due_words[due_head % DUE_DEPTH];
                    due_head++;
                    check_field("triggered", want.triggered, got.triggered);
                    check_field("cause", want.cause, got.cause);
                    check_field("hit_total", want.hits, got.hits);
                    check_field("miss_total", want.misses, got.misses);
                    check_field("window_fill", want.fill, got.fill);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fbwd_pkg::CFG_ABS_LIMIT: abs_limit = i_cfg_wdata[fbwd_pkg::LIMIT_W-1:0];
                    fbwd_pkg::CFG_REL_RATE: rate_q8 = i_cfg_wdata[fbwd_pkg::RATE_W-1:0];
                    fbwd_pkg::CFG_WIN_LEN: begin
                        win_len_reg = i_cfg_wdata[fbwd_pkg::WLEN_W-1:0];
                        clear_window();
                    end
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (due_tail - due_head >= DUE_DEPTH) begin
                    $error("more words outstanding than the pipeline can hold");
                    mismatch_count++;
                end else begin
                    due_words[due_tail % DUE_DEPTH] = advance_window(s_axis_tuser, s_axis_tdata);
                    due_tail++;
                end
            end
        end
        o_pending <= due_tail - due_head;
    end

endmodule

// ----- sim/failure_burst_window_detector_unit_test.sv -----
// Testbench top for the failure burst window detector: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module failure_burst_window_detector_unit_test;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata = '0;   // [15:0] failure_count
    logic [1:0]                      s_axis_tuser = fbwd_pkg::MODE_STEP;  // [1:0] mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [71:0]                     m_axis_tdata;  // [31:0] hit_total, [63:32] miss_total,
                                                    // [68:64] fill
    logic [2:0]                      m_axis_tuser;  // [0] triggered, [2:1] cause
    logic                            i_cfg_we = 1'b0;
    logic [fbwd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = fbwd_pkg::CFG_ABS_LIMIT;
    logic [fbwd_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int mismatches;
    int pending;

    bit quiet = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int words_sent = 0;
    int cur_limit = fbwd_pkg::ABS_LIMIT_RST;

    always #10 i_clk = ~i_clk;

    failure_burst_window_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    failure_burst_window_detector_unit_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_axis_tready <= 1'b0;
            hold_left <= 300;
            holds_served <= holds_served + 1;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [15:0] cnt);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= cnt;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // we stays high across the three writes
    task automatic load_settings(input logic [15:0] limit, input logic [11:0] rate,
                                 input logic [4:0] len);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= fbwd_pkg::CFG_ABS_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_idx <= fbwd_pkg::CFG_REL_RATE;
        i_cfg_wdata <= fbwd_pkg::CFG_DATA_W'(rate);
        @(posedge i_clk);
        i_cfg_idx <= fbwd_pkg::CFG_WIN_LEN;
        i_cfg_wdata <= fbwd_pkg::CFG_DATA_W'(len);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_limit = limit;
    endtask

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r == 0) return fbwd_pkg::MODE_RESET;
        if (r == 1) return fbwd_pkg::MODE_UPDATE;
        if (r < 45) return fbwd_pkg::MODE_CHECK;
        return fbwd_pkg::MODE_STEP;
    endfunction

    // Mostly counts near a steady level so the mean floor and relative test both matter
    function automatic logic [15:0] pick_count(input int level);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'(level + $urandom_range(0, 15));
        if (r < 70) return 16'($urandom_range(0, 400));
        if (r < 85) return 16'($urandom);
        if (cur_limit > 65531) return 16'(65535 - $urandom_range(0, 4));
        if (cur_limit < 2) return 16'($urandom_range(0, 4));
        return 16'(cur_limit - 2 + $urandom_range(0, 4));
    endfunction

    initial begin : stimulus
        int level;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: limit 100, rate 1.0, length 10
        send_word(fbwd_pkg::MODE_CHECK, 16'd50);          // window empty
        repeat (10) send_word(fbwd_pkg::MODE_STEP, 16'd20);
        send_word(fbwd_pkg::MODE_CHECK, 16'd40);          // excess equals allowed: no fire
        send_word(fbwd_pkg::MODE_CHECK, 16'd41);          // relative
        send_word(fbwd_pkg::MODE_CHECK, 16'd101);         // absolute and relative, absolute wins
        send_word(fbwd_pkg::MODE_STEP, 16'hFFFF);         // oldest drops out
        send_word(fbwd_pkg::MODE_CHECK, 16'd0);
        send_word(fbwd_pkg::MODE_UPDATE, 16'd0);
        send_word(fbwd_pkg::MODE_CHECK, 16'd7);           // cleared window
        send_word(fbwd_pkg::MODE_RESET, 16'hFFFF);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase != 0) begin
                drain_results();
                case (phase)
                    1: load_settings(16'd0, 12'd0, 5'd1);
                    2: load_settings(16'hFFFF, 12'd4095, 5'd16);
                    3: load_settings(16'd30, 12'd64, 5'd4);
                    4: load_settings(16'd50, 12'd128, 5'd0);    // zero length acts as one
                    5: load_settings(16'd200, 12'd512, 5'd31);  // clipped to the maximum
                    6: load_settings(16'($urandom), 12'($urandom), 5'd17);
                    default: load_settings(16'd25, 12'd32, 5'd8);
                endcase
            end
            quiet <= (phase == 3);
            if (phase == 2) hold_requests <= hold_requests + 1;
            level = $urandom_range(0, 40);
            repeat (180) send_word(pick_mode(), pick_count(level));
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d words over 8 register settings, window lengths 0 to 31,", words_sent);
        $display("limit and rate at both ends, with stalls, a long hold-off and a quiet stretch.");
        if (mismatches == 0) begin
            $display("failure_burst_window_detector_unit_test: clean");
        end else begin
            $display("failure_burst_window_detector_unit_test: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("failure_burst_window_detector_unit_test: errors");
        $finish;
    end

endmodule
